### sv/assert_macros.svh
// Assertion macros used by the checker file of the scan encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipping cycles in reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/fdsse_pkg.sv
// Package: field widths, segment masks and lookup functions of the scan encoder.
`timescale 1ns / 1ps

package fdsse_pkg;

   localparam int VALUE_W   = 14;
   localparam int WORD_W    = 16;
   localparam int DIGIT_W   = 4;
   localparam int MARK_W    = 6;
   localparam int SEG_COUNT = 7;
   localparam int SEG_IDX_W = 3;
   localparam int POS_IDX_W = 3;

   // Reciprocal of ten for the digit split: q = (x * RECIP_TEN) >> RECIP_SHIFT.
   localparam int          PROD_W      = VALUE_W + 16;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [15:0] RECIP_TEN   = 16'd52429;

   localparam logic [WORD_W-1:0] SEG_A  = 16'h0040;
   localparam logic [WORD_W-1:0] SEG_B  = 16'h0080;
   localparam logic [WORD_W-1:0] SEG_C  = 16'h0020;
   localparam logic [WORD_W-1:0] SEG_D  = 16'h0001;
   localparam logic [WORD_W-1:0] SEG_E  = 16'h0100;
   localparam logic [WORD_W-1:0] SEG_F  = 16'h0008;
   localparam logic [WORD_W-1:0] SEG_G  = 16'h0400;
   localparam logic [WORD_W-1:0] SEG_DP = 16'h0200;
   localparam logic [WORD_W-1:0] ALL_SEGS =
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G | SEG_DP;
   localparam logic [WORD_W-1:0] MARK_BASE = ALL_SEGS & ~SEG_DP;

   localparam logic [WORD_W-1:0] SEL_POS1  = 16'h8000;
   localparam logic [WORD_W-1:0] SEL_POS2  = 16'h4000;
   localparam logic [WORD_W-1:0] SEL_POS3  = 16'h1000;
   localparam logic [WORD_W-1:0] SEL_POS4  = 16'h0800;
   localparam logic [WORD_W-1:0] SEL_COLON = 16'h2000;
   localparam logic [WORD_W-1:0] SEL_UPPER = 16'h0004;

   // Segment driven low in a given step, A to G.
   function automatic logic [WORD_W-1:0] seg_mask(input logic [SEG_IDX_W-1:0] seg);
      logic [WORD_W-1:0] m;
      case (seg)
         3'd0:    m = SEG_A;
         3'd1:    m = SEG_B;
         3'd2:    m = SEG_C;
         3'd3:    m = SEG_D;
         3'd4:    m = SEG_E;
         3'd5:    m = SEG_F;
         3'd6:    m = SEG_G;
         default: m = '0;
      endcase
      return m;
   endfunction

   // Segments held high (off) for each decimal digit.
   function automatic logic [WORD_W-1:0] digit_off(input logic [DIGIT_W-1:0] dig);
      logic [WORD_W-1:0] m;
      case (dig)
         4'd0:    m = 16'h0600;
         4'd1:    m = 16'h0749;
         4'd2:    m = 16'h0228;
         4'd3:    m = 16'h0308;
         4'd4:    m = 16'h0341;
         4'd5:    m = 16'h0380;
         4'd6:    m = 16'h02C0;
         4'd7:    m = 16'h0709;
         4'd8:    m = 16'h0200;
         4'd9:    m = 16'h0301;
         default: m = ALL_SEGS;
      endcase
      return m;
   endfunction

   // Position select; digits past the fourth have none.
   function automatic logic [WORD_W-1:0] pos_bits(input logic [POS_IDX_W-1:0] idx);
      logic [WORD_W-1:0] m;
      case (idx)
         3'd0:    m = SEL_POS1;
         3'd1:    m = SEL_POS2;
         3'd2:    m = SEL_POS3;
         3'd3:    m = SEL_POS4;
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [WORD_W-1:0] mark_word(input logic [MARK_W-1:0] en);
      logic [WORD_W-1:0] w;
      w = MARK_BASE;
      if (en[0]) w = w | SEL_POS1;
      if (en[1]) w = w | SEL_POS2;
      if (en[2]) w = w | SEL_POS3;
      if (en[3]) w = w | SEL_POS4;
      if (en[4]) w = w | SEL_COLON;
      if (en[5]) w = w | SEL_UPPER;
      return w;
   endfunction

endpackage

### sv/fdsse_queue.sv
// Two-entry queue between the digit splitter and the word sequencer.
`timescale 1ns / 1ps

module fdsse_queue #(
   parameter int WIDTH = 22
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/fdsse_front.sv
// Front end: accepts a request and splits the value into decimal digits.
`timescale 1ns / 1ps

module fdsse_front #(
   parameter int DIGIT_COUNT = 4,
   parameter int DIG_IDX_W   = 2,
   parameter int ENTRY_W     = 22
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic [fdsse_pkg::VALUE_W-1:0]    req_value,
   output logic                             req_full,
   input  logic [fdsse_pkg::MARK_W-1:0]     marker_enable,
   output logic                             q_push,
   output logic [ENTRY_W-1:0]               q_data,
   input  logic                             q_full
);
   import fdsse_pkg::*;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [DIG_IDX_W-1:0]                cnt_ff;
   logic [VALUE_W-1:0]                  rest_ff;
   logic [MARK_W-1:0]                   mark_ff;
   logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_ff;
   logic                                accept;
   logic [PROD_W-1:0]                   prod;
   logic [VALUE_W-1:0]                  quot;
   logic [VALUE_W-1:0]                  quot_x10;
   logic [VALUE_W-1:0]                  rem;

   assign req_full = busy_ff;
   assign accept   = req_push && !busy_ff;
   assign q_push   = done_ff;
   assign q_data   = {mark_ff, digits_ff};

   // Divide by ten through the reciprocal; exact over the whole value range.
   assign prod     = PROD_W'(rest_ff) * PROD_W'(RECIP_TEN);
   assign quot     = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
   assign quot_x10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
   assign rem      = rest_ff - quot_x10;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (busy_ff && !done_ff) begin
         if (cnt_ff == '0) begin
            done_in = 1'b1;
         end
      end else if (done_ff && !q_full) begin
         busy_in = 1'b0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Least significant digit first, stored from the top position down.
   always_ff @(posedge clock) begin
      if (accept) begin
         rest_ff <= req_value;
         mark_ff <= marker_enable;
         cnt_ff  <= DIG_IDX_W'(DIGIT_COUNT - 1);
      end else if (busy_ff && !done_ff) begin
         digits_ff[cnt_ff] <= rem[DIGIT_W-1:0];
         rest_ff           <= quot;
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIG_IDX_W'(1);
         end
      end
   end

endmodule

### sv/fdsse_back.sv
// Back end: steps through digits and segments and drives the word register.
`timescale 1ns / 1ps

module fdsse_back #(
   parameter int DIGIT_COUNT = 4,
   parameter int DIG_IDX_W   = 2,
   parameter int ENTRY_W     = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  logic [ENTRY_W-1:0]            q_data,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [fdsse_pkg::WORD_W-1:0]  rsp_drive_word,
   output logic                          rsp_last
);
   import fdsse_pkg::*;

   logic [SEG_IDX_W-1:0] seg_ff;
   logic [DIG_IDX_W-1:0] dig_ff;
   logic                 mark_phase_ff;
   logic                 out_valid_ff;
   logic [WORD_W-1:0]    word_ff;
   logic                 last_ff;
   logic                 load;
   logic [DIGIT_W-1:0]   cur_digit;
   logic [MARK_W-1:0]    cur_mark;
   logic [WORD_W-1:0]    cur_word;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_drive_word = word_ff;
   assign rsp_last       = last_ff;

   assign load      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = load && mark_phase_ff;
   assign cur_digit = q_data[{dig_ff, 2'b00} +: DIGIT_W];
   assign cur_mark  = q_data[ENTRY_W-1 -: MARK_W];

   always_comb begin
      if (mark_phase_ff) begin
         cur_word = mark_word(cur_mark);
      end else begin
         cur_word = (ALL_SEGS & ~seg_mask(seg_ff)) | digit_off(cur_digit)
                  | pos_bits(POS_IDX_W'(dig_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff        <= '0;
         dig_ff        <= '0;
         mark_phase_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
         if (mark_phase_ff) begin
            mark_phase_ff <= 1'b0;
            seg_ff        <= '0;
            dig_ff        <= '0;
         end else if (seg_ff == SEG_IDX_W'(SEG_COUNT - 1)) begin
            seg_ff <= '0;
            if (dig_ff == DIG_IDX_W'(DIGIT_COUNT - 1)) begin
               mark_phase_ff <= 1'b1;
            end else begin
               dig_ff <= dig_ff + DIG_IDX_W'(1);
            end
         end else begin
            seg_ff <= seg_ff + SEG_IDX_W'(1);
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= cur_word;
         last_ff <= mark_phase_ff;
      end
   end

endmodule

### sv/four_digit_segment_scan_encoder_unit.sv
// Top level of the four-digit segment scan encoder.
//
//   channel   ports                         handshake
//   request   req_value                     req_push / req_full
//   response  rsp_drive_word, rsp_last      rsp_empty / rsp_pop
//   csr       csr_marker_enable             csr_valid / csr_ready
//
// Each request yields DIGIT_COUNT*7+1 response words (29 by default), one per
// cycle while rsp_pop is held; the word sequencer in the back end sets this rate.
// The front end splits one digit per cycle, then hands the digits to the queue
// once it has room; req_full stays high until then, so it takes no new request while one is in progress.
// When the queue and back end are idle, the first word is loaded into the back end's
// word register once the digits of the accepted request reach the queue.
// Reset is synchronous; it clears the queue, the control flags and sequencer
// counters, and the marker register.
// A stalled response holds the back end; the two-entry queue then fills and req_full stays high.
`timescale 1ns / 1ps

module four_digit_segment_scan_encoder_unit #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [fdsse_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [fdsse_pkg::WORD_W-1:0]  rsp_drive_word,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fdsse_pkg::MARK_W-1:0]  csr_marker_enable
);
   import fdsse_pkg::*;

   localparam int DIG_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int ENTRY_W   = DIGIT_COUNT * DIGIT_W + MARK_W;

   logic [MARK_W-1:0]  marker_ff;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_push_data;
   logic [ENTRY_W-1:0] q_head_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         marker_ff <= csr_marker_enable;
      end
   end

   fdsse_front #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .DIG_IDX_W   (DIG_IDX_W),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_value     (req_value),
      .req_full      (req_full),
      .marker_enable (marker_ff),
      .q_push        (q_push),
      .q_data        (q_push_data),
      .q_full        (q_full)
   );

   fdsse_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head_data)
   );

   fdsse_back #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .DIG_IDX_W   (DIG_IDX_W),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_head_data),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_drive_word (rsp_drive_word),
      .rsp_last       (rsp_last)
   );

endmodule

### sv/fdsse_checker.sv
// Port-level checks of the scan encoder, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdsse_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_full,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [fdsse_pkg::WORD_W-1:0] rsp_drive_word,
   input logic                         rsp_last
);
   import fdsse_pkg::*;

   // Come out of reset with nothing pending and room for a request.
   `ASSERT_ALWAYS(a_reset_clears, reset |=> (rsp_empty && !req_full), "not idle after reset")

   // Hold a waiting response word until it is popped.
   `ASSERT_CLK(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_drive_word) && $stable(rsp_last)), "response changed while stalled")

   // Marker word: every segment off, decimal point lit.
   `ASSERT_CLK(a_mark_base, (!rsp_empty && rsp_last) |-> ((rsp_drive_word & ALL_SEGS) == MARK_BASE), "bad marker word segments")

   // Digit word: decimal point off, no colon or upper mark.
   `ASSERT_CLK(a_digit_marks, (!rsp_empty && !rsp_last) |-> ((rsp_drive_word & (SEG_DP | SEL_COLON | SEL_UPPER)) == SEG_DP), "marker bits in digit word")

   // Digit word: light at most one segment.
   `ASSERT_CLK(a_one_segment, (!rsp_empty && !rsp_last) |-> ($countones(~rsp_drive_word & MARK_BASE) <= 1), "several segments lit")

endmodule

bind four_digit_segment_scan_encoder_unit fdsse_checker u_checker (.*);
